// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on clk_i, off while rst_ni is low
`define DMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication on clk_i, off while rst_ni is low
`define DMR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmr_pkg.sv =====
`default_nettype none

package dmr_pkg;

  localparam int FieldW   = 16;
  localparam int RuleIdxW = 4;
  localparam int CountW   = 5;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } dmr_state_e;

endpackage

`default_nettype wire

// ===== rtl/dependency_mask_reduction.sv =====
// a query applies the active rules to the subset in passes until the subset stops changing,
// at most MASK_BITS + 1 passes; with no active rules the subset is returned unchanged; one
// rule is read from the rule memory and applied per cycle
// one load per cycle while idle; a new request is taken only when the block is idle
// reset (async, active low) clears the rule count and control state, not the rule memory
`default_nettype none

`include "assert_macros.svh"

module dependency_mask_reduction #(
  parameter int MAX_RULES = 16,
  parameter int MASK_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dmr_pkg::CountW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic [dmr_pkg::RuleIdxW-1:0]  rule_index_i,
  input  wire logic [dmr_pkg::FieldW-1:0]    dependent_mask_i,
  input  wire logic [dmr_pkg::FieldW-1:0]    given_mask_i,
  input  wire logic [dmr_pkg::FieldW-1:0]    subset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dmr_pkg::FieldW-1:0]         reduced_subset_o
);
  import dmr_pkg::*;

  localparam int AddrW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CntW  = $clog2(MAX_RULES + 1);
  localparam int PassW = $clog2(MASK_BITS + 1);
  localparam int WideW = (MASK_BITS > FieldW) ? MASK_BITS : FieldW;

  // rule memory
  logic [MASK_BITS-1:0] dep_mem [MAX_RULES];
  logic [MASK_BITS-1:0] giv_mem [MAX_RULES];
  logic [MASK_BITS-1:0] dep_rd_q;
  logic [MASK_BITS-1:0] giv_rd_q;

  logic [CountW-1:0] rule_count_q;
  dmr_state_e        state_q, state_d;
  logic [AddrW-1:0]  issue_q, issue_d;
  logic              pend_vld_q, pend_vld_d;
  logic              pend_last_q, pend_last_d;
  logic [PassW-1:0]  pass_q, pass_d;
  logic [MASK_BITS-1:0] s_q, s_d;
  logic [MASK_BITS-1:0] before_q, before_d;
  logic              out_vld_q, out_vld_d;
  logic [FieldW-1:0] res_q, res_d;

  logic              in_acc;
  logic              load_acc;
  logic              query_acc;
  logic              wr_ok;
  logic [CntW-1:0]   n_act;
  logic [CntW-1:0]   top_w;
  logic [AddrW-1:0]  top_addr;
  logic [WideW-1:0]  dep_w, giv_w, sub_w, res_w;
  logic [MASK_BITS-1:0] sub_in;
  logic [MASK_BITS-1:0] s_app;
  logic              fire;
  logic              out_free;

  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_vld_q;
  assign reduced_subset_o = res_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign load_acc  = in_acc && (mode_i == ModeLoad);
  assign query_acc = in_acc && (mode_i == ModeQuery);
  assign wr_ok     = (32'(rule_index_i) < MAX_RULES);

  // count above the table depth saturates
  assign n_act    = (32'(rule_count_q) > MAX_RULES) ? CntW'(MAX_RULES) : CntW'(rule_count_q);
  assign top_w    = n_act - CntW'(1);
  assign top_addr = top_w[AddrW-1:0];

  assign dep_w  = WideW'(dependent_mask_i);
  assign giv_w  = WideW'(given_mask_i);
  assign sub_w  = WideW'(subset_i);
  assign sub_in = sub_w[MASK_BITS-1:0];

  assign fire  = ((giv_rd_q & s_q) == giv_rd_q);
  assign s_app = (pend_vld_q && fire) ? ((s_q & ~dep_rd_q) | giv_rd_q) : s_q;
  assign res_w = WideW'(s_app);

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (load_acc && wr_ok) begin
      dep_mem[AddrW'(rule_index_i)] <= dep_w[MASK_BITS-1:0];
      giv_mem[AddrW'(rule_index_i)] <= giv_w[MASK_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dep_rd_q <= dep_mem[issue_q];
    giv_rd_q <= giv_mem[issue_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
    end else if (cfg_we_i) begin
      rule_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issue_q     <= '0;
      pend_vld_q  <= 1'b0;
      pend_last_q <= 1'b0;
      pass_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      pend_vld_q  <= pend_vld_d;
      pend_last_q <= pend_last_d;
      pass_q      <= pass_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    before_q <= before_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    pend_vld_d  = 1'b0;
    pend_last_d = 1'b0;
    pass_d      = pass_q;
    s_d         = s_q;
    before_d    = before_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (query_acc) begin
          s_d      = sub_in;
          before_d = sub_in;
          pass_d   = '0;
          issue_d  = top_addr;
          if (n_act == '0) begin
            state_d = StHold;
          end else begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        // reads run one rule ahead of the apply step, wrapping to the top rule
        pend_vld_d  = 1'b1;
        pend_last_d = (issue_q == '0);
        issue_d     = (issue_q == '0) ? top_addr : issue_q - AddrW'(1);
        s_d         = s_app;
        if (pend_vld_q && pend_last_q) begin
          if ((s_app == before_q) || (pass_q == PassW'(MASK_BITS))) begin
            pend_vld_d  = 1'b0;
            pend_last_d = 1'b0;
            if (out_free) begin
              res_d     = res_w[FieldW-1:0];
              out_vld_d = 1'b1;
              state_d   = StIdle;
            end else begin
              state_d = StHold;
            end
          end else begin
            pass_d   = pass_q + PassW'(1);
            before_d = s_app;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          res_d     = res_w[FieldW-1:0];
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  `DMR_ASSERT_IMPL(a_pend_only_run, pend_vld_q, state_q == StRun,
                   "rule data pending outside a reduction")
  `DMR_ASSERT_IMPL(a_pass_bound, state_q == StRun, pass_q <= PassW'(MASK_BITS),
                   "pass count beyond limit")
  `DMR_ASSERT(a_bits_fall, (state_q == StRun && pend_vld_q) |=> ((s_q & ~$past(s_q)) == '0),
              "subset gained a bit during reduction")

endmodule

`default_nettype wire
